[src/tpzr_pkg.sv]
package tpzr_pkg;

	// One input item and one result item.
	typedef struct packed {
		logic        func;
		logic [14:0] ring_angle;
		logic [14:0] sweep_angle;
	} in_item_t;

	typedef struct packed {
		logic [7:0] column;
		logic [6:0] row;
		logic [3:0] shade_index;
		logic [1:0] color_class;
	} out_item_t;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_A  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_B  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_LEN  = 3'd4;

	localparam logic [8:0] COLUMNS_RST = 9'd80;
	localparam logic [7:0] ROWS_RST    = 8'd24;
	localparam logic [4:0] MAP_LEN_RST = 5'd12;

	localparam int MAX_COLUMNS_DEF = 256;
	localparam int MAX_ROWS_DEF    = 128;

	// Shared unit widths.
	localparam int DEN_W  = 19;
	localparam int QUOT_W = 31;

	typedef struct packed {
		logic        start;
		logic [14:0] angle;
	} cordic_req_t;

	typedef struct packed {
		logic               done;
		logic signed [15:0] sin_v;
		logic signed [15:0] cos_v;
	} cordic_rsp_t;

	typedef struct packed {
		logic             start;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CSTART,
		ST_CWAIT,
		ST_MUL,
		ST_DSTART,
		ST_DWAIT,
		ST_SCALE,
		ST_DIV3,
		ST_ADDR,
		ST_READ,
		ST_CMP,
		ST_EMIT
	} state_t;

	localparam logic [1:0] COLOR_DEFAULT = 2'd0;
	localparam logic [1:0] COLOR_BRIGHT  = 2'd1;
	localparam logic [1:0] COLOR_MID     = 2'd2;
	localparam logic [1:0] COLOR_SHADOW  = 2'd3;

endpackage

[src/tpzr_cordic.sv]
module tpzr_cordic (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tpzr_pkg::cordic_req_t req,
	output tpzr_pkg::cordic_rsp_t rsp
);

	localparam int ITER = 16;
	localparam logic signed [16:0] TURN    = 17'sd25736;
	localparam logic signed [16:0] HALF    = 17'sd12868;
	localparam logic signed [16:0] QUARTER = 17'sd6434;
	localparam logic signed [16:0] THREE_Q = 17'sd19302;
	localparam logic signed [27:0] GAIN    = 28'sd10188014;

	function automatic logic signed [19:0] atan_q16(input logic [3:0] k);
		logic signed [19:0] r;
		case (k)
			4'd0:    r = 20'sd51472;
			4'd1:    r = 20'sd30385;
			4'd2:    r = 20'sd16055;
			4'd3:    r = 20'sd8150;
			4'd4:    r = 20'sd4091;
			4'd5:    r = 20'sd2047;
			4'd6:    r = 20'sd1024;
			4'd7:    r = 20'sd512;
			4'd8:    r = 20'sd256;
			4'd9:    r = 20'sd128;
			4'd10:   r = 20'sd64;
			4'd11:   r = 20'sd32;
			4'd12:   r = 20'sd16;
			4'd13:   r = 20'sd8;
			4'd14:   r = 20'sd4;
			default: r = 20'sd2;
		endcase
		return r;
	endfunction

	// Round half up to Q.14 and clamp to one.
	function automatic logic signed [15:0] to_q14(input logic signed [27:0] v);
		logic signed [27:0] r;
		r = (v + 28'sd512) >>> 10;
		if (r > 28'sd16384) begin
			r = 28'sd16384;
		end else if (r < -28'sd16384) begin
			r = -28'sd16384;
		end
		return r[15:0];
	endfunction

	logic               busy_q;
	logic               done_q;
	logic [3:0]         k_q;
	logic signed [27:0] x_q;
	logic signed [27:0] y_q;
	logic signed [19:0] z_q;
	logic               neg_q;

	logic signed [16:0] r0;
	logic signed [16:0] r1;
	logic signed [16:0] r2;
	logic               neg_d;
	logic signed [27:0] dx;
	logic signed [27:0] dy;
	logic signed [19:0] at;
	logic signed [15:0] s14;
	logic signed [15:0] c14;

	// Fold the angle into the right half plane.
	always_comb begin
		r0 = signed'({2'b00, req.angle});
		r1 = r0;
		if (r0 >= TURN) begin
			r1 = r0 - TURN;
		end
		r2 = r1;
		neg_d = 1'b0;
		if (r1 > QUARTER) begin
			if (r1 < THREE_Q) begin
				r2 = r1 - HALF;
				neg_d = 1'b1;
			end else begin
				r2 = r1 - TURN;
			end
		end
	end

	assign dx = y_q >>> k_q;
	assign dy = x_q >>> k_q;
	assign at = atan_q16(k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= busy_q && !req.start && (k_q == 4'(ITER - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				k_q <= k_q + 4'd1;
				if (k_q == 4'(ITER - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q   <= GAIN;
			y_q   <= '0;
			z_q   <= 20'(r2) <<< 4;
			neg_q <= neg_d;
		end else if (busy_q) begin
			if (!z_q[19]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign s14 = to_q14(y_q);
	assign c14 = to_q14(x_q);

	assign rsp.done  = done_q;
	assign rsp.sin_v = neg_q ? -s14 : s14;
	assign rsp.cos_v = neg_q ? -c14 : c14;

endmodule

[src/tpzr_div.sv]
module tpzr_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tpzr_pkg::div_req_t req,
	output tpzr_pkg::div_rsp_t rsp
);

	localparam int DW = tpzr_pkg::DEN_W;
	localparam int QW = tpzr_pkg::QUOT_W;
	localparam logic [QW-1:0] NUMER = QW'(1) << 30;

	logic          busy_q;
	logic          done_q;
	logic [4:0]    cnt_q;
	logic [QW-1:0] num_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;

	logic [DW:0]   sh;
	logic          take;

	// Restoring division, one quotient bit a cycle.
	assign sh   = {rem_q, num_q[QW-1]};
	assign take = (sh >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !req.start && (cnt_q == 5'(QW - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(QW - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= NUMER;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= take ? DW'(sh - {1'b0, den_q}) : DW'(sh);
			num_q <= {num_q[QW-2:0], take};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = num_q;

endmodule

[src/tpzr_zbuf.sv]
module tpzr_zbuf #(
	parameter int DEPTH = tpzr_pkg::MAX_COLUMNS_DEF * tpzr_pkg::MAX_ROWS_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [15:0]              wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [15:0]              rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/torus_point_zbuffer_render_top.sv]
// Torus point renderer with depth buffer.
// Input channel (in_valid/in_ready/in_item): a plot item carries two Q3.12 angles of one
// torus surface point; a clear item (func set) zeroes the whole depth buffer.
// Output channel (out_valid/out_ready/out_item): at most one pixel per plot item, sent
// only when the point lands on screen and is nearer than the stored depth.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index at the clock edge;
// write only while the block is idle.
// Sequencing: one item at a time. A plot item makes four runs of the shared CORDIC unit,
// 18 products through the one shared multiplier with one pass through the radix-2
// reciprocal divider before the last two, then scaling, depth buffer read and compare.
// A clear item writes MAX_COLUMNS*MAX_ROWS buffer entries, one buffer entry a cycle.
// Reset: config registers return to defaults and the block runs the same clearing pass
// with in_ready low before it takes the first item.
// Stall: a finished pixel sits in the output register; the next item is accepted
// meanwhile and the block waits only when a second pixel is ready before the first left.
module torus_point_zbuffer_render_top #(
	parameter int MAX_COLUMNS = tpzr_pkg::MAX_COLUMNS_DEF,
	parameter int MAX_ROWS    = tpzr_pkg::MAX_ROWS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  tpzr_pkg::in_item_t                  in_item,
	output logic                                out_valid,
	input  logic                                out_ready,
	output tpzr_pkg::out_item_t                 out_item,
	input  logic                                cfg_wr_en,
	input  logic [tpzr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tpzr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_COLUMNS + 1);
	localparam int RW    = $clog2(MAX_ROWS + 1);

	// Angle slots of the CORDIC pass.
	localparam logic [1:0] SC_RING  = 2'd0;
	localparam logic [1:0] SC_SWEEP = 2'd1;
	localparam logic [1:0] SC_A     = 2'd2;
	localparam logic [1:0] SC_B     = 2'd3;

	// Multiplier program steps.
	localparam logic [4:0] MS_SIH   = 5'd0;
	localparam logic [4:0] MS_CIH   = 5'd1;
	localparam logic [4:0] MS_SSA   = 5'd2;
	localparam logic [4:0] MS_SCA   = 5'd3;
	localparam logic [4:0] MS_DEN   = 5'd4;
	localparam logic [4:0] MS_T     = 5'd5;
	localparam logic [4:0] MS_PX0   = 5'd6;
	localparam logic [4:0] MS_PX1   = 5'd7;
	localparam logic [4:0] MS_PY0   = 5'd8;
	localparam logic [4:0] MS_PY1   = 5'd9;
	localparam logic [4:0] MS_SICJ  = 5'd10;
	localparam logic [4:0] MS_CICJ  = 5'd11;
	localparam logic [4:0] MS_U     = 5'd12;
	localparam logic [4:0] MS_N0    = 5'd13;
	localparam logic [4:0] MS_N1    = 5'd14;
	localparam logic [4:0] MS_N2    = 5'd15;
	localparam logic [4:0] MS_DPX   = 5'd16;
	localparam logic [4:0] MS_DPY   = 5'd17;

	tpzr_pkg::state_t state_q, state_d;

	// Configuration registers.
	logic [14:0] angle_a_q;
	logic [14:0] angle_b_q;
	logic [8:0]  scr_cols_q;
	logic [7:0]  scr_rows_q;
	logic [4:0]  map_len_q;

	// Sequencer control.
	logic [AW-1:0] clr_addr_q;
	logic [1:0]    cord_idx_q;
	logic [4:0]    step_q;
	logic          phase_q;
	logic          out_valid_q;

	// Datapath.
	logic [14:0]        ring_q;
	logic [14:0]        sweep_q;
	logic signed [15:0] sj_q, cj_q, si_q, ci_q, sa_q, ca_q, sb_q, cb_q;
	logic signed [39:0] prod_q;
	logic signed [19:0] sih_q, cih_q, ssa_q, sca_q, den_q, t_q, px_q, py_q;
	logic signed [19:0] sicj_q, cicj_q, u_q, n_q;
	logic [15:0]        d_q;
	logic signed [35:0] dpx_q, dpy_q;
	logic signed [47:0] tx_q, ty_q;
	logic [CW-1:0]      qx_q;
	logic [RW-1:0]      qy_q;
	logic               on_q;
	logic [AW-1:0]      addr_q;
	tpzr_pkg::out_item_t out_item_q;

	tpzr_pkg::cordic_req_t cord_req;
	tpzr_pkg::cordic_rsp_t cord_rsp;
	tpzr_pkg::div_req_t    div_req;
	tpzr_pkg::div_rsp_t    div_rsp;

	logic          zb_we;
	logic [AW-1:0] zb_waddr;
	logic [15:0]   zb_wdata;
	logic [15:0]   zb_rdata;

	logic               accept;
	logic               slot_free;
	logic               hit;
	logic [CW-1:0]      cols;
	logic [RW-1:0]      rows;
	logic [4:0]         len5;
	logic signed [19:0] h;
	logic signed [19:0] op_a, op_b;
	logic signed [19:0] p14;
	logic signed [CW+1:0] two_cols;
	logic signed [RW+1:0] two_rows;
	logic [47:0]        hc, hr;
	logic signed [47:0] half_x, half_y;
	logic [47:0]        mag_x, mag_y;
	logic [32:0]        q3x, q3y;
	logic               on_x, on_y;
	logic               n_pos;
	logic [7:0]         nn;
	logic [3:0]         shade;
	logic [1:0]         color;

	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;

	// Screen and map limits saturate at their maxima; a map length of zero counts as one.
	always_comb begin
		cols = (32'(scr_cols_q) > 32'(MAX_COLUMNS)) ? CW'(MAX_COLUMNS) : CW'(scr_cols_q);
		rows = (32'(scr_rows_q) > 32'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(scr_rows_q);
		if (map_len_q == 5'd0) begin
			len5 = 5'd1;
		end else if (map_len_q > 5'd16) begin
			len5 = 5'd16;
		end else begin
			len5 = map_len_q;
		end
	end

	// Shared unit instances.
	tpzr_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cord_req),
		.rsp    (cord_rsp)
	);

	tpzr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	tpzr_zbuf #(
		.DEPTH (DEPTH)
	) u_zbuf (
		.clk   (clk),
		.we    (zb_we),
		.waddr (zb_waddr),
		.wdata (zb_wdata),
		.raddr (addr_q),
		.rdata (zb_rdata)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			tpzr_pkg::ST_CLEAR: begin
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					state_d = tpzr_pkg::ST_IDLE;
				end
			end
			tpzr_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = in_item.func ? tpzr_pkg::ST_CLEAR : tpzr_pkg::ST_CSTART;
				end
			end
			tpzr_pkg::ST_CSTART: state_d = tpzr_pkg::ST_CWAIT;
			tpzr_pkg::ST_CWAIT: begin
				if (cord_rsp.done) begin
					state_d = (cord_idx_q == SC_B) ? tpzr_pkg::ST_MUL : tpzr_pkg::ST_CSTART;
				end
			end
			tpzr_pkg::ST_MUL: begin
				if (phase_q && step_q == MS_N2) begin
					state_d = tpzr_pkg::ST_DSTART;
				end else if (phase_q && step_q == MS_DPY) begin
					state_d = tpzr_pkg::ST_SCALE;
				end
			end
			tpzr_pkg::ST_DSTART: state_d = tpzr_pkg::ST_DWAIT;
			tpzr_pkg::ST_DWAIT: begin
				if (div_rsp.done) begin
					state_d = tpzr_pkg::ST_MUL;
				end
			end
			tpzr_pkg::ST_SCALE: state_d = tpzr_pkg::ST_DIV3;
			tpzr_pkg::ST_DIV3:  state_d = tpzr_pkg::ST_ADDR;
			tpzr_pkg::ST_ADDR:  state_d = on_q ? tpzr_pkg::ST_READ : tpzr_pkg::ST_IDLE;
			tpzr_pkg::ST_READ:  state_d = tpzr_pkg::ST_CMP;
			tpzr_pkg::ST_CMP:   state_d = hit ? tpzr_pkg::ST_EMIT : tpzr_pkg::ST_IDLE;
			tpzr_pkg::ST_EMIT: begin
				if (slot_free) begin
					state_d = tpzr_pkg::ST_IDLE;
				end
			end
			default: state_d = tpzr_pkg::ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, unit starts and buffer writes.
	always_comb begin
		in_ready       = (state_q == tpzr_pkg::ST_IDLE);
		cord_req.start = (state_q == tpzr_pkg::ST_CSTART);
		div_req.start  = (state_q == tpzr_pkg::ST_DSTART);
		hit            = (d_q > zb_rdata);
		zb_we          = 1'b0;
		zb_waddr       = addr_q;
		zb_wdata       = d_q;
		if (state_q == tpzr_pkg::ST_CLEAR) begin
			zb_we    = 1'b1;
			zb_waddr = clr_addr_q;
			zb_wdata = '0;
		end else if (state_q == tpzr_pkg::ST_CMP && hit) begin
			zb_we = 1'b1;
		end
	end

	// Pick the angle for the current CORDIC run.
	always_comb begin
		case (cord_idx_q)
			SC_RING:  cord_req.angle = ring_q;
			SC_SWEEP: cord_req.angle = sweep_q;
			SC_A:     cord_req.angle = angle_a_q;
			default:  cord_req.angle = angle_b_q;
		endcase
	end

	localparam logic [tpzr_pkg::DEN_W-1:0] DEN_ONE = tpzr_pkg::DEN_W'(1);
	assign div_req.den = (den_q < 20'sd1) ? DEN_ONE : den_q[tpzr_pkg::DEN_W-1:0];

	// Operand select for the shared multiplier.
	assign h = 20'(cj_q) + 20'sd32768;

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (step_q)
			MS_SIH:  begin op_a = 20'(si_q);   op_b = h;          end
			MS_CIH:  begin op_a = 20'(ci_q);   op_b = h;          end
			MS_SSA:  begin op_a = 20'(sj_q);   op_b = 20'(sa_q);  end
			MS_SCA:  begin op_a = 20'(sj_q);   op_b = 20'(ca_q);  end
			MS_DEN:  begin op_a = sih_q;       op_b = 20'(sa_q);  end
			MS_T:    begin op_a = sih_q;       op_b = 20'(ca_q);  end
			MS_PX0:  begin op_a = cih_q;       op_b = 20'(cb_q);  end
			MS_PX1:  begin op_a = t_q;         op_b = 20'(sb_q);  end
			MS_PY0:  begin op_a = cih_q;       op_b = 20'(sb_q);  end
			MS_PY1:  begin op_a = t_q;         op_b = 20'(cb_q);  end
			MS_SICJ: begin op_a = 20'(si_q);   op_b = 20'(cj_q);  end
			MS_CICJ: begin op_a = 20'(ci_q);   op_b = 20'(cj_q);  end
			MS_U:    begin op_a = sicj_q;      op_b = 20'(ca_q);  end
			MS_N0:   begin op_a = u_q;         op_b = 20'(cb_q);  end
			MS_N1:   begin op_a = sicj_q;      op_b = 20'(sa_q);  end
			MS_N2:   begin op_a = cicj_q;      op_b = 20'(sb_q);  end
			MS_DPX:  begin op_a = signed'(20'(d_q)); op_b = px_q; end
			MS_DPY:  begin op_a = signed'(20'(d_q)); op_b = py_q; end
			default: begin op_a = '0;          op_b = '0;         end
		endcase
	end

	// Floor of the product over 2^14.
	assign p14 = 20'(prod_q >>> 14);

	// Screen scaling: center offset (cols/2)*3*2^30 plus 2*cols*D*p.
	assign two_cols = signed'({1'b0, cols, 1'b0});
	assign two_rows = signed'({1'b0, rows, 1'b0});
	assign hc       = 48'(cols >> 1);
	assign hr       = 48'(rows >> 1);
	assign half_x   = signed'((hc << 31) + (hc << 30));
	assign half_y   = signed'((hr << 31) + (hr << 30));

	// Truncate toward zero: divide the magnitude by 2^30, then by 3 with a reciprocal.
	assign mag_x = tx_q[47] ? 48'(-tx_q) : 48'(tx_q);
	assign mag_y = ty_q[47] ? 48'(-ty_q) : 48'(ty_q);
	assign q3x   = ({15'b0, mag_x[47:30]} * 33'd21846) >> 16;
	assign q3y   = ({15'b0, mag_y[47:30]} * 33'd21846) >> 16;
	assign on_x  = !(tx_q[47] && q3x != 33'd0) && (q3x < 33'(cols));
	assign on_y  = !(ty_q[47] && q3y != 33'd0) && (q3y < 33'(rows));

	// Shade and color from the luminance; only N at or above 1/8 counts.
	always_comb begin
		n_pos = !n_q[19] && (n_q[18:11] != 8'd0);
		nn    = n_q[18:11];
		shade = 4'd0;
		color = tpzr_pkg::COLOR_DEFAULT;
		if (n_pos) begin
			shade = (nn < 8'(len5)) ? nn[3:0] : 4'(len5 - 5'd1);
			if (nn > 8'd8) begin
				color = tpzr_pkg::COLOR_BRIGHT;
			end else if (nn > 8'd4) begin
				color = tpzr_pkg::COLOR_MID;
			end else begin
				color = tpzr_pkg::COLOR_SHADOW;
			end
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tpzr_pkg::ST_CLEAR;
			clr_addr_q  <= '0;
			cord_idx_q  <= '0;
			step_q      <= '0;
			phase_q     <= 1'b0;
			out_valid_q <= 1'b0;
			angle_a_q   <= '0;
			angle_b_q   <= '0;
			scr_cols_q  <= tpzr_pkg::COLUMNS_RST;
			scr_rows_q  <= tpzr_pkg::ROWS_RST;
			map_len_q   <= tpzr_pkg::MAP_LEN_RST;
		end else begin
			state_q <= state_d;
			// Sweep the buffer one entry a cycle.
			if (state_q == tpzr_pkg::ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			if (accept) begin
				clr_addr_q <= '0;
				cord_idx_q <= '0;
				step_q     <= '0;
				phase_q    <= 1'b0;
			end
			if (state_q == tpzr_pkg::ST_CWAIT && cord_rsp.done) begin
				cord_idx_q <= cord_idx_q + 2'd1;
			end
			// Multiply on phase 0, accumulate on phase 1, then advance.
			if (state_q == tpzr_pkg::ST_MUL) begin
				phase_q <= !phase_q;
				if (phase_q) begin
					step_q <= step_q + 5'd1;
				end
			end
			// Hold the pixel until taken.
			if (state_q == tpzr_pkg::ST_EMIT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				case (cfg_index)
					tpzr_pkg::CFG_ANGLE_A: angle_a_q  <= cfg_data;
					tpzr_pkg::CFG_ANGLE_B: angle_b_q  <= cfg_data;
					tpzr_pkg::CFG_COLUMNS: scr_cols_q <= cfg_data[8:0];
					tpzr_pkg::CFG_ROWS:    scr_rows_q <= cfg_data[7:0];
					tpzr_pkg::CFG_MAP_LEN: map_len_q  <= cfg_data[4:0];
					default: ;
				endcase
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			ring_q  <= in_item.ring_angle;
			sweep_q <= in_item.sweep_angle;
		end
		if (state_q == tpzr_pkg::ST_CWAIT && cord_rsp.done) begin
			case (cord_idx_q)
				SC_RING:  begin sj_q <= cord_rsp.sin_v; cj_q <= cord_rsp.cos_v; end
				SC_SWEEP: begin si_q <= cord_rsp.sin_v; ci_q <= cord_rsp.cos_v; end
				SC_A:     begin sa_q <= cord_rsp.sin_v; ca_q <= cord_rsp.cos_v; end
				default:  begin sb_q <= cord_rsp.sin_v; cb_q <= cord_rsp.cos_v; end
			endcase
		end
		if (state_q == tpzr_pkg::ST_MUL) begin
			if (!phase_q) begin
				prod_q <= op_a * op_b;
			end else begin
				case (step_q)
					MS_SIH:  sih_q  <= p14;
					MS_CIH:  cih_q  <= p14;
					MS_SSA:  ssa_q  <= p14;
					MS_SCA:  sca_q  <= p14;
					MS_DEN:  den_q  <= p14 + sca_q + 20'sd81920;
					MS_T:    t_q    <= p14 - ssa_q;
					MS_PX0:  px_q   <= p14;
					MS_PX1:  px_q   <= px_q - p14;
					MS_PY0:  py_q   <= p14;
					MS_PY1:  py_q   <= py_q + p14;
					MS_SICJ: sicj_q <= p14;
					MS_CICJ: cicj_q <= p14;
					MS_U:    u_q    <= ssa_q - p14;
					MS_N0:   n_q    <= p14 - sca_q;
					MS_N1:   n_q    <= n_q - p14;
					MS_N2:   n_q    <= n_q - p14;
					MS_DPX:  dpx_q  <= 36'(prod_q);
					MS_DPY:  dpy_q  <= 36'(prod_q);
					default: ;
				endcase
			end
		end
		// Saturate the reciprocal depth to Q0.16.
		if (state_q == tpzr_pkg::ST_DWAIT && div_rsp.done) begin
			d_q <= (div_rsp.quot > tpzr_pkg::QUOT_W'(65535)) ? 16'hFFFF : div_rsp.quot[15:0];
		end
		if (state_q == tpzr_pkg::ST_SCALE) begin
			tx_q <= dpx_q * two_cols + half_x;
			ty_q <= dpy_q * two_rows + half_y;
		end
		if (state_q == tpzr_pkg::ST_DIV3) begin
			qx_q <= CW'(q3x);
			qy_q <= RW'(q3y);
			on_q <= on_x && on_y;
		end
		if (state_q == tpzr_pkg::ST_ADDR) begin
			addr_q <= AW'(32'(qy_q) * 32'(MAX_COLUMNS) + 32'(qx_q));
		end
		if (state_q == tpzr_pkg::ST_EMIT && slot_free) begin
			out_item_q.column      <= 8'(qx_q);
			out_item_q.row         <= 7'(qy_q);
			out_item_q.shade_index <= shade;
			out_item_q.color_class <= color;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

`ifndef ASSERT_OFF
	// A new pixel only comes out of the emit step.
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == tpzr_pkg::ST_EMIT))
		else $error("pixel raised outside emit step");

	// An accepted item always leaves idle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != tpzr_pkg::ST_IDLE)
		else $error("accepted item did not start work");

	// Shared units finish only while the sequencer waits on them.
	a_cordic_done: assert property (@(posedge clk) disable iff (!arst_n)
		cord_rsp.done |-> state_q == tpzr_pkg::ST_CWAIT)
		else $error("cordic result outside its wait step");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == tpzr_pkg::ST_DWAIT)
		else $error("divider result outside its wait step");
`endif

endmodule
